// ===== rtl/kernel_window_convolution_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef KERNEL_WINDOW_CONVOLUTION_MACROS_SVH
`define KERNEL_WINDOW_CONVOLUTION_MACROS_SVH

// implication check on a clock with async active-low reset
`define KWC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication check
`define KWC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/kwc_pkg.sv =====
package kwc_pkg;
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COEF_W  = 16;
	localparam int unsigned CIDX_W  = 7;
	localparam int unsigned CFG_W   = 11;
	localparam int unsigned POS_W   = 10;
	localparam int unsigned SUM_W   = 32;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// classified beat from the front to the back
	typedef struct packed {
		logic               is_pix;
		logic [CIDX_W-1:0]  cidx;
		logic [COEF_W-1:0]  coef;
		logic [PIX_W-1:0]   pix;
		logic [11:0]        col;
		logic               first_row;
		logic               emit;
		logic [POS_W-1:0]   orow;
		logic [POS_W-1:0]   ocol;
		logic               last;
	} kwc_cmd_t;
endpackage

// ===== rtl/kernel_window_convolution.sv =====
// kernel window convolution
// in channel (in_valid/in_ready): action 0 loads coef_value at coef_index
// into the kernel, action 1 delivers one pixel in raster order.
// out channel (out_valid/out_ready): one result per interior center, with
// its row, column and a frame_last flag on the final one of the frame.
// cfg port: cfg_we with cfg_index 0 (width) or 1 (height); any write
// restarts the frame; write only while idle.
// path: a pixel that completes a window passes the fifo, line store read,
// column, window, products, row sums and total, then the output register.
// throughput: one beat per clock unless the output stalls, set by the
// single read and write port of each line store ram and the fully parallel
// multiplier array.
// reset clears counters, the kernel (all zero) and the queues; line stores
// hold nothing until the first rows pass.
// when out_ready stays low the two-entry output buffer fills, the pipe
// stops, the four-entry queue fills and then in_ready drops.
module kernel_window_convolution #(
	parameter int unsigned KERNEL_SIZE = 9,
	parameter int unsigned MAX_WIDTH   = 1024,
	parameter int unsigned MAX_HEIGHT  = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [kwc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [kwc_pkg::CIDX_W-1:0]  coef_index,
	input  logic [kwc_pkg::COEF_W-1:0]  coef_value,
	input  logic [kwc_pkg::PIX_W-1:0]   pixel,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [kwc_pkg::SUM_W-1:0]   filtered,
	output logic [kwc_pkg::POS_W-1:0]   out_row,
	output logic [kwc_pkg::POS_W-1:0]   out_col,
	output logic                        frame_last
);
	import kwc_pkg::*;

	logic     q_valid, q_ready;
	kwc_cmd_t q_cmd;

	kwc_front #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT))
	u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_valid_idx(1'b1), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .coef_index(coef_index), .coef_value(coef_value), .pixel(pixel),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	kwc_back #(.KERNEL_SIZE(KERNEL_SIZE), .MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_valid(out_valid), .out_ready(out_ready),
		.filtered(filtered), .out_row(out_row), .out_col(out_col), .frame_last(frame_last)
	);
endmodule

// ===== rtl/kwc_ram.sv =====
module kwc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/kwc_front.sv =====
module kwc_front #(
	parameter int unsigned KERNEL_SIZE = 9,
	parameter int unsigned MAX_WIDTH   = 1024,
	parameter int unsigned MAX_HEIGHT  = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic                         cfg_valid_idx,
	input  logic [kwc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [kwc_pkg::CIDX_W-1:0]   coef_index,
	input  logic [kwc_pkg::COEF_W-1:0]   coef_value,
	input  logic [kwc_pkg::PIX_W-1:0]    pixel,
	output logic                         q_valid,
	input  logic                         q_ready,
	output kwc_pkg::kwc_cmd_t            q_cmd
);
	import kwc_pkg::*;
	`include "kernel_window_convolution_macros.svh"

	localparam int unsigned HIST = KERNEL_SIZE - 1;
	localparam int unsigned MID  = (KERNEL_SIZE - 1) / 2;
	localparam int unsigned QD   = 4;

	logic [CFG_W-1:0] width_q, height_q;
	logic [11:0] row_q, col_q;
	logic [12:0] w_eff, h_eff;
	logic [11:0] r, c, c_nx, r_nx;
	logic fire;
	kwc_cmd_t cmd;

	// clamp register values to the supported range
	always_comb begin
		if (width_q == '0) w_eff = 13'd1;
		else if ({2'b0, width_q} > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		else w_eff = {2'b0, width_q};
		if (height_q == '0) h_eff = 13'd1;
		else if ({2'b0, height_q} > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
		else h_eff = {2'b0, height_q};
		c = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
		r = ({1'b0, row_q} >= h_eff) ? '0 : row_q;
		if ({1'b0, c} + 13'd1 >= w_eff) begin
			c_nx = '0;
			r_nx = ({1'b0, r} + 13'd1 >= h_eff) ? '0 : r + 12'd1;
		end else begin
			c_nx = c + 12'd1;
			r_nx = r;
		end
	end

	always_comb begin
		cmd.is_pix    = (action == ACT_PIXEL);
		cmd.cidx      = coef_index;
		cmd.coef      = coef_value;
		cmd.pix       = pixel;
		cmd.col       = c;
		cmd.first_row = 1'b0;
		cmd.emit      = (r >= 12'(HIST)) && (c >= 12'(HIST));
		cmd.orow      = POS_W'(r - 12'(HIST) + 12'(MID));
		cmd.ocol      = POS_W'(c - 12'(HIST) + 12'(MID));
		cmd.last      = ({1'b0, r} == h_eff - 13'd1) && ({1'b0, c} == w_eff - 13'd1);
	end

	// small fifo toward the back
	kwc_cmd_t    fifo_q [QD];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign in_ready = (cnt_q != 3'(QD));
	assign fire     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = fifo_q[rp_q];
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (fire) fifo_q[wp_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			width_q <= CFG_W'(1024);
			height_q <= CFG_W'(1024);
			row_q <= '0;
			col_q <= '0;
		end else begin
			if (fire) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, fire} - {2'b0, pop};
			if (cfg_we && cfg_valid_idx) begin
				if (cfg_idx == REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
				row_q <= '0;
				col_q <= '0;
			end else if (fire && cmd.is_pix) begin
				row_q <= r_nx;
				col_q <= c_nx;
			end
		end
	end

	`KWC_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, cnt_q <= 3'(QD), "fifo count overflow")
	`KWC_ASSERT_NXT(a_no_push_full, clk, arst_n, cnt_q == 3'(QD) && !pop,
		cnt_q == 3'(QD), "fifo full lost state")
	`KWC_ASSERT_IMP(a_col_range, clk, arst_n, fire && cmd.is_pix,
		{1'b0, c} < w_eff, "column outside frame")
endmodule

// ===== rtl/kwc_back.sv =====
module kwc_back #(
	parameter int unsigned KERNEL_SIZE = 9,
	parameter int unsigned MAX_WIDTH   = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  kwc_pkg::kwc_cmd_t          q_cmd,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [kwc_pkg::SUM_W-1:0]  filtered,
	output logic [kwc_pkg::POS_W-1:0]  out_row,
	output logic [kwc_pkg::POS_W-1:0]  out_col,
	output logic                       frame_last
);
	import kwc_pkg::*;
	`include "kernel_window_convolution_macros.svh"

	localparam int unsigned K    = KERNEL_SIZE;
	localparam int unsigned HIST = K - 1;
	localparam int unsigned KK   = K * K;
	localparam int unsigned AW   = $clog2(MAX_WIDTH);
	localparam int unsigned PW   = 25;
	localparam int unsigned RW   = PW + $clog2(K) + 1;
	// stages: s1 ram read, s2 column, s3 window, then products, row sums, total
	localparam int unsigned NST  = 6;

	logic adv;
	logic [NST:1] v_s;
	logic [NST:1] e_s;
	logic [3:1]   ld_s;

	// output skid: two entries so the pipe only stops when both are full
	logic [1:0] ocnt_q;
	assign q_ready = adv;

	// pipeline stops only when a result in the last stage has no room
	assign adv = !(v_s[NST] && e_s[NST]) || (ocnt_q != 2'd2) || out_ready;

	logic        take;
	kwc_cmd_t    c_s1, c_s2, c_s3;
	assign take = q_valid && adv;

	kwc_cmd_t cmd_in;
	assign cmd_in = q_cmd;

	// kernel coefficients in flops, every tap is read at a fixed place;
	// writes trail by three stages so pixels already taken keep the old kernel
	logic [COEF_W-1:0] coef_q [KK];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KK; i++) coef_q[i] <= '0;
		end else if (adv && ld_s[3]) begin
			coef_q[c_s3.cidx] <= c_s3.coef;
		end
	end

	// line stores: one ram per history line, read then written at the column
	logic [PIX_W-1:0] lrd [HIST];
	logic [PIX_W-1:0] col_s2 [K];
	logic             fwd_s1;
	logic [PIX_W-1:0] wr_col [HIST];
	logic [PIX_W-1:0] prev_col [HIST];
	logic [PIX_W-1:0] lwd [HIST];

	// back-to-back same column cannot occur unless width is one
	always_comb begin
		for (int j = 0; j < HIST; j++) begin
			prev_col[j] = fwd_s1 ? wr_col[j] : lrd[j];
		end
		for (int j = 0; j < HIST - 1; j++) begin
			lwd[j] = prev_col[j + 1];
		end
		lwd[HIST - 1] = c_s1.pix;
	end

	genvar g;
	generate
		for (g = 0; g < HIST; g++) begin : g_line
			kwc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
				.clk   (clk),
				.we    (adv && v_s[1] && c_s1.is_pix),
				.waddr (c_s1.col[AW-1:0]),
				.wdata (lwd[g]),
				.re    (take),
				.raddr (cmd_in.col[AW-1:0]),
				.rdata (lrd[g])
			);
			assign wr_col[g] = col_s2[g + 1];
		end
	endgenerate

	logic [PIX_W-1:0] win_q [K][K];
	logic signed [PW-1:0] prod_s3 [K][K];
	logic signed [RW-1:0] rsum_s4 [K];
	logic signed [SUM_W-1:0] tot_s5;
	logic signed [RW-1:0] rsum_d [K];
	logic signed [SUM_W-1:0] tot_d;
	logic [POS_W-1:0] r_s2, r_s3, r_s4, r_s5, r_s6, cc_s2, cc_s3, cc_s4, cc_s5, cc_s6;
	logic l_s2, l_s3, l_s4, l_s5, l_s6;

	always_comb begin
		for (int i = 0; i < K; i++) begin
			rsum_d[i] = '0;
			for (int j = 0; j < K; j++) rsum_d[i] = rsum_d[i] + RW'(prod_s3[i][j]);
		end
		tot_d = '0;
		for (int i = 0; i < K; i++) tot_d = tot_d + SUM_W'(rsum_s4[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
			e_s <= '0;
			ld_s <= '0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			v_s <= {v_s[NST-1:1], take && cmd_in.is_pix};
			e_s <= {e_s[NST-1:1], cmd_in.emit};
			ld_s <= {ld_s[2:1], take && !cmd_in.is_pix && cmd_in.cidx < CIDX_W'(KK)};
			fwd_s1 <= take && cmd_in.is_pix && v_s[1] && c_s1.is_pix
				&& cmd_in.col == c_s1.col;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= cmd_in;
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			if (v_s[1]) begin
				for (int j = 0; j < HIST; j++) col_s2[j] <= prev_col[j];
				col_s2[HIST] <= c_s1.pix;
			end
			r_s2 <= c_s1.orow;
			cc_s2 <= c_s1.ocol;
			l_s2 <= c_s1.last;
			if (v_s[2]) begin
				for (int i = 0; i < K; i++) begin
					for (int j = 0; j < K - 1; j++) win_q[i][j] <= win_q[i][j + 1];
					win_q[i][K - 1] <= col_s2[i];
				end
			end
			r_s3 <= r_s2; cc_s3 <= cc_s2; l_s3 <= l_s2;
			r_s4 <= r_s3; cc_s4 <= cc_s3; l_s4 <= l_s3;
			r_s5 <= r_s4; cc_s5 <= cc_s4; l_s5 <= l_s4;
			r_s6 <= r_s5; cc_s6 <= cc_s5; l_s6 <= l_s5;
			for (int i = 0; i < K; i++) begin
				for (int j = 0; j < K; j++) begin
					prod_s3[i][j] <= PW'($signed({1'b0, win_q[i][j]})
						* $signed(coef_q[i * K + j]));
				end
			end
			for (int i = 0; i < K; i++) rsum_s4[i] <= rsum_d[i];
			tot_s5 <= tot_d;
		end
	end

	// window registers take the column written in s2 and move only on pixel
	// beats; products are registered from the updated window on each advance
	logic emit5;
	assign emit5 = adv && v_s[NST] && e_s[NST];

	logic [SUM_W-1:0] of_q [2];
	logic [POS_W-1:0] or_q [2], oc_q [2];
	logic             ol_q [2];
	logic             pop;
	logic             to_head;
	assign out_valid = (ocnt_q != 0);
	assign pop = out_valid && out_ready;
	assign to_head = pop ? (ocnt_q == 2'd1) : (ocnt_q == 2'd0);
	assign filtered = of_q[0];
	assign out_row = or_q[0];
	assign out_col = oc_q[0];
	assign frame_last = ol_q[0];

	always_ff @(posedge clk) begin
		if (emit5 && to_head) begin
			of_q[0] <= tot_s5; or_q[0] <= r_s6; oc_q[0] <= cc_s6; ol_q[0] <= l_s6;
		end else if (pop) begin
			of_q[0] <= of_q[1]; or_q[0] <= or_q[1]; oc_q[0] <= oc_q[1]; ol_q[0] <= ol_q[1];
		end
		if (emit5 && !to_head) begin
			of_q[1] <= tot_s5; or_q[1] <= r_s6; oc_q[1] <= cc_s6; ol_q[1] <= l_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ocnt_q <= '0;
		else ocnt_q <= ocnt_q + {1'b0, emit5} - {1'b0, pop};
	end

	`KWC_ASSERT_IMP(a_skid_bound, clk, arst_n, 1'b1, ocnt_q <= 2'd2, "skid overflow")
	`KWC_ASSERT_IMP(a_no_emit_full, clk, arst_n, ocnt_q == 2'd2 && !out_ready,
		!emit5, "result dropped")
	`KWC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid, "result vanished")
endmodule
